// ----- rtl/rle_spr_pkg.sv -----
// ----------------------------------------------------------------------------
// rle_spr_pkg
// Shared constants, codes and types of the run-length sprite store.
// ----------------------------------------------------------------------------
package rle_spr_pkg;

    localparam int MAX_ROWS_DEF   = 512;
    localparam int DATA_BYTES_DEF = 131072;

    localparam int MAX_WIDTH  = 300;
    localparam int MAX_HEIGHT = 500;
    localparam int MAX_TOTAL  = 100 * 1024;

    localparam logic [1:0] FN_ROW    = 2'd0;
    localparam logic [1:0] FN_DATA   = 2'd1;
    localparam logic [1:0] FN_VERIFY = 2'd2;
    localparam logic [1:0] FN_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SIZE   = 2'd1;
    localparam logic [1:0] ST_OFFSET = 2'd2;
    localparam logic [1:0] ST_RUN    = 2'd3;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LENGTH = 2'd2;

    typedef struct packed {
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [16:0] data_length;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] pixel;
        logic [1:0] status;
    } t_res;

endpackage

// ----- rtl/rle_spr_if.sv -----
// ----------------------------------------------------------------------------
// rle_spr interfaces
// Valid/ready channels for items, results and register writes.
// ----------------------------------------------------------------------------
interface rle_spr_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [8:0]  row_index;
    logic [31:0] raw_offset;
    logic [16:0] data_address;
    logic [7:0]  data_byte;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    modport source (output valid, func, row_index, raw_offset, data_address,
                    data_byte, x_pos, y_pos, input ready);
    modport sink (input valid, func, row_index, raw_offset, data_address,
                  data_byte, x_pos, y_pos, output ready);
endinterface

interface rle_spr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel;
    logic [1:0] status;
    modport source (output valid, pixel, status, input ready);
    modport sink (input valid, pixel, status, output ready);
endinterface

interface rle_spr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [16:0] wdata;
    modport source (output valid, addr, wdata, input ready);
    modport sink (input valid, addr, wdata, output ready);
endinterface

// ----- rtl/rle_spr_seq.sv -----
// ----------------------------------------------------------------------------
// rle_spr_seq
// Sequencer with row table and run data memories; walks run chains one
// memory read per cycle for verify and pixel queries.
// ----------------------------------------------------------------------------
module rle_spr_seq
    import rle_spr_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rle_spr_in_if.sink    in_ch,
    input  t_cfg          i_cfg,
    input  logic          i_res_ready,
    output t_res          o_res
);

    localparam int RW = $clog2(MAX_ROWS);
    localparam int AW = $clog2(DATA_BYTES);

    typedef enum logic [2:0] {
        S_IDLE, S_VCHK, S_VROW, S_ENT, S_HD, S_CT, S_RUN, S_DONE
    } t_state;

    t_state r_state, n_state;
    logic          r_is_query, n_is_query;
    logic [RW-1:0] r_row, n_row;
    logic [17:0]   r_off, n_off;
    logic [16:0]   r_xpos, n_xpos;
    logic [7:0]    r_head, n_head;
    logic [15:0]   r_x, n_x;
    logic [7:0]    r_pixel, n_pixel;
    logic [1:0]    r_status, n_status;
    logic          r_offset_err, n_offset_err;

    logic [17:0] row_mem [MAX_ROWS];
    logic [7:0]  data_mem [DATA_BYTES];
    logic [17:0] r_row_q;
    logic [7:0]  r_data_q;

    logic          row_we, data_we;
    logic [RW-1:0] row_wa, row_ra;
    logic [17:0]   row_wd;
    logic [AW-1:0] data_wa, data_ra;

    logic        accept;
    logic [16:0] len_q;
    logic [31:0] wr_dest;
    logic        size_bad;
    logic [18:0] sum_total;
    logic        row_last;
    logic [17:0] off_n;
    logic [16:0] vx_n, qx, qdiff;
    logic [18:0] qaddr;

    assign in_ch.ready  = (r_state == S_IDLE);
    assign accept       = in_ch.valid && in_ch.ready;
    assign o_res.valid  = (r_state == S_DONE);
    assign o_res.pixel  = r_pixel;
    assign o_res.status = r_status;

    // usable length for queries: data length clipped to the store size
    assign len_q = (32'(i_cfg.data_length) > DATA_BYTES) ? 17'(DATA_BYTES)
                                                          : i_cfg.data_length;
    assign wr_dest   = in_ch.raw_offset - {14'd0, i_cfg.image_height, 2'b00};
    assign sum_total = {2'b00, i_cfg.data_length} + {1'b0, i_cfg.image_height, 2'b00};
    assign size_bad  = (i_cfg.image_width == 16'd0)
                    || (32'(i_cfg.image_width) > MAX_WIDTH)
                    || (i_cfg.image_height == 16'd0)
                    || (32'(i_cfg.image_height) > MAX_HEIGHT)
                    || (32'(i_cfg.image_height) > MAX_ROWS)
                    || (i_cfg.data_length == 17'd0)
                    || (32'(i_cfg.data_length) > DATA_BYTES)
                    || (32'(sum_total) > MAX_TOTAL);
    assign row_last  = (16'(r_row) + 16'd1 == i_cfg.image_height);

    // shared walk arithmetic, r_data_q holds the count byte in S_RUN
    assign off_n = r_off + 18'd2 + {10'd0, r_data_q};
    assign vx_n  = r_xpos + {10'd0, r_head[6:0]} + {9'd0, r_data_q};
    assign qx    = r_xpos + {10'd0, r_head[6:0]};
    assign qdiff = {1'b0, r_x} - qx;
    assign qaddr = {1'b0, r_off} + 19'd2 + {2'b00, qdiff};

    always_comb begin
        n_state      = r_state;
        n_is_query   = r_is_query;
        n_row        = r_row;
        n_off        = r_off;
        n_xpos       = r_xpos;
        n_head       = r_head;
        n_x          = r_x;
        n_pixel      = r_pixel;
        n_status     = r_status;
        n_offset_err = r_offset_err;
        row_we       = 1'b0;
        row_wa       = RW'(in_ch.row_index);
        row_wd       = 18'h20000;
        data_we      = 1'b0;
        data_wa      = AW'(in_ch.data_address);
        row_ra       = r_row;
        data_ra      = AW'(r_off[16:0]);
        case (r_state)
            S_IDLE: begin
                row_ra = RW'(in_ch.y_pos);
                if (accept) begin
                    n_pixel  = 8'd0;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    n_x      = in_ch.x_pos;
                    case (in_ch.func)
                        FN_ROW: begin
                            if (32'(in_ch.row_index) < MAX_ROWS) begin
                                if (in_ch.raw_offset == 32'd0) begin
                                    row_we = 1'b1;
                                end else if (wr_dest >= {15'd0, i_cfg.data_length}) begin
                                    n_offset_err = 1'b1;
                                end else begin
                                    row_we = 1'b1;
                                    row_wd = {1'b0, wr_dest[16:0]};
                                end
                            end
                            if (n_offset_err) begin
                                n_status = ST_OFFSET;
                            end
                        end
                        FN_DATA: begin
                            data_we = (32'(in_ch.data_address) < DATA_BYTES);
                        end
                        FN_VERIFY: begin
                            n_is_query = 1'b0;
                            n_state    = S_VCHK;
                        end
                        default: begin
                            n_is_query = 1'b1;
                            if (in_ch.x_pos < i_cfg.image_width
                                && in_ch.y_pos < i_cfg.image_height
                                && 32'(in_ch.y_pos) < MAX_ROWS) begin
                                n_state = S_ENT;
                            end
                        end
                    endcase
                end
            end
            S_VCHK: begin
                n_row = '0;
                if (size_bad) begin
                    n_status = ST_SIZE;
                    n_state  = S_DONE;
                end else if (r_offset_err) begin
                    n_status = ST_OFFSET;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_VROW;
                end
            end
            S_VROW: begin
                n_state = S_ENT;
            end
            S_ENT: begin
                n_off  = {1'b0, r_row_q[16:0]};
                n_xpos = 17'd0;
                if (!r_row_q[17]) begin
                    n_state = S_HD;
                end else if (r_is_query || row_last) begin
                    n_state = S_DONE;
                end else begin
                    n_row   = r_row + RW'(1);
                    n_state = S_VROW;
                end
            end
            S_HD: begin
                if (r_is_query ? ({1'b0, r_off} + 19'd1 >= {2'b00, len_q})
                               : ({1'b0, r_off} + 19'd2 >= {2'b00, i_cfg.data_length})) begin
                    n_status = r_is_query ? ST_OK : ST_RUN;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_CT;
                end
            end
            S_CT: begin
                data_ra = AW'(r_off[16:0] + 17'd1);
                n_head  = r_data_q;
                n_state = S_RUN;
            end
            S_RUN: begin
                if (r_is_query) begin
                    data_ra = AW'(qaddr[16:0]);
                    if (qx > {1'b0, r_x}) begin
                        n_state = S_DONE;
                    end else if (qdiff < {9'd0, r_data_q}) begin
                        // pixel read issued now, data lands in r_data_q during the S_VROW wait
                        n_state = (qaddr < {2'b00, len_q}) ? S_VROW : S_DONE;
                    end else begin
                        n_xpos  = qx + {9'd0, r_data_q};
                        n_off   = off_n;
                        n_state = r_head[7] ? S_DONE : S_HD;
                    end
                end else begin
                    n_xpos = vx_n;
                    n_off  = off_n;
                    if (!r_head[7]) begin
                        if (vx_n >= {1'b0, i_cfg.image_width}
                            || off_n >= {1'b0, i_cfg.data_length}) begin
                            n_status = ST_RUN;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_HD;
                        end
                    end else if (vx_n > {1'b0, i_cfg.image_width}
                                 || off_n > {1'b0, i_cfg.data_length}) begin
                        n_status = ST_RUN;
                        n_state  = S_DONE;
                    end else if (row_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_row   = r_row + RW'(1);
                        n_state = S_VROW;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // a query passes S_VROW only while its pixel read is in flight
        if (r_state == S_VROW && r_is_query) begin
            n_pixel = r_data_q;
            n_state = S_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_offset_err <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_offset_err <= n_offset_err;
        end
        r_is_query <= n_is_query;
        r_row      <= n_row;
        r_off      <= n_off;
        r_xpos     <= n_xpos;
        r_head     <= n_head;
        r_x        <= n_x;
        r_pixel    <= n_pixel;
        r_status   <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (row_we) begin
            row_mem[row_wa] <= row_wd;
        end
        r_row_q <= row_mem[row_ra];
    end

    always_ff @(posedge i_clk) begin
        if (data_we) begin
            data_mem[data_wa] <= in_ch.data_byte;
        end
        r_data_q <= data_mem[data_ra];
    end

endmodule

// ----- rtl/rle_sprite_store_pixel_fetch_core.sv -----
// ----------------------------------------------------------------------------
// rle_sprite_store_pixel_fetch_core
// Run-length sprite store with verify and pixel fetch, top level.
// ----------------------------------------------------------------------------
// One item at a time. The run data memory has a single read port, so the
// header and count bytes of each run are read one after the other. The
// result sits in an output register, so the sink may stall without losing
// it; a new item is taken once the result has left the sequencer. The user
// must write the registers only while the block is idle; the block itself
// does not enforce this.
module rle_sprite_store_pixel_fetch_core
    import rle_spr_pkg::*;
#(
    parameter int MAX_ROWS   = MAX_ROWS_DEF,
    parameter int DATA_BYTES = DATA_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rle_spr_in_if.sink     i_in,
    rle_spr_out_if.source  o_out,
    rle_spr_cfg_if.sink    i_cfg
);

    t_cfg       r_cfg;
    t_res       w_res;
    logic       w_res_ready;
    logic       r_out_valid;
    logic [7:0] r_out_pixel;
    logic [1:0] r_out_status;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                CFG_WIDTH:  r_cfg.image_width  <= i_cfg.wdata[15:0];
                CFG_HEIGHT: r_cfg.image_height <= i_cfg.wdata[15:0];
                CFG_LENGTH: r_cfg.data_length  <= i_cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    rle_spr_seq #(
        .MAX_ROWS   (MAX_ROWS),
        .DATA_BYTES (DATA_BYTES)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .in_ch       (i_in),
        .i_cfg       (r_cfg),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // output register takes a result while empty or draining; else the sequencer waits in S_DONE
    assign w_res_ready = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res.valid;
        end
        if (w_res_ready && w_res.valid) begin
            r_out_pixel  <= w_res.pixel;
            r_out_status <= w_res.status;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.pixel  = r_out_pixel;
    assign o_out.status = r_out_status;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken again right after a transfer");

    a_pixel_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status != ST_OK |-> o_out.pixel == 8'd0)
        else $error("nonzero pixel with an error status");

    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid && !w_res_ready |=> w_res.valid)
        else $error("sequencer result dropped while output stalled");

endmodule

// ----- dv/tb_rle_sprite_store_pixel_fetch_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rle_sprite_store_pixel_fetch_core
// Builds run-length sprites of random shape through row and data writes,
// verifies them and fetches pixels, with corrupted sprites mixed in and
// bad row offsets sent last. Every result is checked against an in-bench
// model of the store; both channel sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_rle_sprite_store_pixel_fetch_core;
    import rle_spr_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [8:0]  row_index;
        logic [31:0] raw_offset;
        logic [16:0] data_address;
        logic [7:0]  data_byte;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
    } sprite_op_t;

    typedef struct {
        logic [7:0] pixel;
        logic [1:0] status;
    } fetch_result_t;

    class sprite_scoreboard;
        fetch_result_t expected_q[$];
        logic [17:0]   row_table[MAX_ROWS_DEF];
        bit            row_written[MAX_ROWS_DEF];
        logic [7:0]    run_bytes[DATA_BYTES_DEF];
        bit            byte_written[DATA_BYTES_DEF];
        bit            offset_err;
        int unsigned   width, height, length;
        int            errors;

        function new();
            offset_err = 0;
            width = 0;
            height = 0;
            length = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] val);
            case (idx)
                CFG_WIDTH: width = val[15:0];
                CFG_HEIGHT: height = val[15:0];
                CFG_LENGTH: length = val;
                default: ;
            endcase
        endfunction

        // ok drops when the walk would touch a never-written entry
        function logic [7:0] fetch_pixel(int unsigned x, int unsigned y, output bit ok);
            int unsigned lim, off, xpos, head, count, addr;
            ok = 1;
            lim = length < DATA_BYTES_DEF ? length : DATA_BYTES_DEF;
            xpos = 0;
            if (x >= width || y >= height || y >= MAX_ROWS_DEF) return '0;
            if (!row_written[y]) begin
                ok = 0;
                return '0;
            end
            if (row_table[y][17]) return '0;
            off = row_table[y][16:0];
            while (1) begin
                if (off + 1 >= lim) return '0;
                if (!byte_written[off] || !byte_written[off + 1]) ok = 0;
                head = run_bytes[off];
                count = run_bytes[off + 1];
                xpos += head & 127;
                if (xpos > x) return '0;
                if (x - xpos < count) begin
                    addr = off + 2 + (x - xpos);
                    if (addr >= lim) return '0;
                    if (!byte_written[addr]) ok = 0;
                    return run_bytes[addr];
                end
                xpos += count;
                off += 2 + count;
                if (head & 128) return '0;
            end
        endfunction

        function logic [1:0] audit_sprite(output bit ok);
            int unsigned off, xpos, head, count;
            ok = 1;
            if (width == 0 || width > MAX_WIDTH) return ST_SIZE;
            if (height == 0 || height > MAX_HEIGHT || height > MAX_ROWS_DEF) return ST_SIZE;
            if (length == 0 || length > DATA_BYTES_DEF) return ST_SIZE;
            if (length + 4 * height > MAX_TOTAL) return ST_SIZE;
            if (offset_err) return ST_OFFSET;
            for (int unsigned r = 0; r < height; r++) begin
                if (!row_written[r]) begin
                    ok = 0;
                    return ST_OK;
                end
                if (row_table[r][17]) continue;
                off = row_table[r][16:0];
                xpos = 0;
                while (1) begin
                    if (off + 2 >= length) return ST_RUN;
                    if (!byte_written[off] || !byte_written[off + 1]) ok = 0;
                    head = run_bytes[off];
                    count = run_bytes[off + 1];
                    xpos += (head & 127) + count;
                    off += 2 + count;
                    if (!(head & 128)) begin
                        if (xpos >= width || off >= length) return ST_RUN;
                    end else begin
                        if (xpos > width || off > length) return ST_RUN;
                        break;
                    end
                end
            end
            return ST_OK;
        endfunction

        function bit harmless(sprite_op_t op);
            bit ok;
            ok = 1;
            if (op.func == FN_VERIFY) void'(audit_sprite(ok));
            else if (op.func == FN_QUERY) void'(fetch_pixel(op.x_pos, op.y_pos, ok));
            return ok;
        endfunction

        function void note_input(sprite_op_t op);
            fetch_result_t res;
            bit ok;
            int unsigned dest;
            res.pixel = 0;
            res.status = ST_OK;
            case (op.func)
                FN_ROW: begin
                    if (op.raw_offset == 0) begin
                        row_table[op.row_index] = 18'h20000;
                        row_written[op.row_index] = 1;
                    end else begin
                        dest = op.raw_offset - 4 * height;
                        if (dest >= length) begin
                            offset_err = 1;
                        end else begin
                            row_table[op.row_index] = {1'b0, dest[16:0]};
                            row_written[op.row_index] = 1;
                        end
                    end
                    res.status = offset_err ? ST_OFFSET : ST_OK;
                end
                FN_DATA: begin
                    run_bytes[op.data_address] = op.data_byte;
                    byte_written[op.data_address] = 1;
                end
                FN_VERIFY: res.status = audit_sprite(ok);
                default: res.pixel = fetch_pixel(op.x_pos, op.y_pos, ok);
            endcase
            expected_q.push_back(res);
        endfunction

        function void check_result(logic [7:0] px, logic [1:0] st);
            fetch_result_t want;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result pixel=%0d status=%0d", px, st);
                return;
            end
            want = expected_q.pop_front();
            if (px !== want.pixel || st !== want.status) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected pixel=%0d status=%0d, got pixel=%0d status=%0d",
                             want.pixel, want.status, px, st);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rle_spr_in_if  in_ch();
    rle_spr_out_if out_ch();
    rle_spr_cfg_if cfg_ch();

    rle_sprite_store_pixel_fetch_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    sprite_scoreboard sb = new();
    bit  calm;
    int  stall_left;
    int  sent;
    logic [7:0] spr_bytes[$];

    initial begin
        i_clk = 0;
        i_rst_n = 0;
        in_ch.valid = 0;
        in_ch.func = FN_ROW;
        in_ch.row_index = 0;
        in_ch.raw_offset = 0;
        in_ch.data_address = 0;
        in_ch.data_byte = 0;
        in_ch.x_pos = 0;
        in_ch.y_pos = 0;
        out_ch.ready = 0;
        cfg_ch.valid = 0;
        cfg_ch.addr = CFG_WIDTH;
        cfg_ch.wdata = 0;
    end

    always #2 i_clk = ~i_clk;

    // monitor: both channels sampled at the rising edge
    always @(posedge i_clk) begin
        sprite_op_t seen;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                seen.func = in_ch.func;
                seen.row_index = in_ch.row_index;
                seen.raw_offset = in_ch.raw_offset;
                seen.data_address = in_ch.data_address;
                seen.data_byte = in_ch.data_byte;
                seen.x_pos = in_ch.x_pos;
                seen.y_pos = in_ch.y_pos;
                sb.note_input(seen);
            end
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result(out_ch.pixel, out_ch.status);
                stall_left = calm ? 0 : $urandom_range(0, 11);
            end
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ch.ready <= 0;
            stall_left--;
        end else begin
            out_ch.ready <= 1;
        end
    end

    function automatic sprite_op_t rand_op(logic [1:0] fn);
        sprite_op_t op;
        op.func = fn;
        op.row_index = 9'($urandom);
        op.raw_offset = $urandom;
        op.data_address = 17'($urandom);
        op.data_byte = 8'($urandom);
        op.x_pos = 16'($urandom);
        op.y_pos = 16'($urandom);
        return op;
    endfunction

    // leaves at the accepting rising edge with valid still high
    task automatic push_op(sprite_op_t op);
        int gap;
        if (!sb.harmless(op)) return;
        gap = calm ? 0 : $urandom_range(0, 11);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.func <= op.func;
        in_ch.row_index <= op.row_index;
        in_ch.raw_offset <= op.raw_offset;
        in_ch.data_address <= op.data_address;
        in_ch.data_byte <= op.data_byte;
        in_ch.x_pos <= op.x_pos;
        in_ch.y_pos <= op.y_pos;
        do @(posedge i_clk); while (!(in_ch.valid && in_ch.ready));
        sent++;
    endtask

    task automatic send_row(int idx, logic [31:0] raw);
        sprite_op_t op;
        op = rand_op(FN_ROW);
        op.row_index = 9'(idx);
        op.raw_offset = raw;
        push_op(op);
    endtask

    task automatic send_byte(int addr, logic [7:0] val);
        sprite_op_t op;
        op = rand_op(FN_DATA);
        op.data_address = 17'(addr);
        op.data_byte = val;
        push_op(op);
    endtask

    task automatic send_query(int x, int y);
        sprite_op_t op;
        op = rand_op(FN_QUERY);
        op.x_pos = 16'(x);
        op.y_pos = 16'(y);
        push_op(op);
    endtask

    // sender holds off until every result is back
    task automatic drain();
        @(negedge i_clk);
        in_ch.valid <= 0;
        while (sb.expected_q.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [16:0] val);
        cfg_ch.valid <= 1;
        cfg_ch.addr <= idx;
        cfg_ch.wdata <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_ch.valid <= 0;
    endtask

    task automatic set_shape(logic [16:0] w, logic [16:0] h, logic [16:0] len);
        drain();
        cfg_write(CFG_WIDTH, w);
        cfg_write(CFG_HEIGHT, h);
        cfg_write(CFG_LENGTH, len);
    endtask

    task automatic build_sprite(int w, int h, bit sparse, bit corrupt);
        int unsigned row_off[MAX_ROWS_DEF];
        bit          row_used[MAX_ROWS_DEF];
        int          xp, rem, s, c, len;
        bit          last;
        spr_bytes.delete();
        for (int r = 0; r < h; r++) begin
            row_used[r] = sparse ? (r < 2 || $urandom_range(0, 99) == 0)
                                 : ($urandom_range(0, 5) != 0);
            if (!row_used[r]) continue;
            row_off[r] = spr_bytes.size();
            xp = 0;
            while (1) begin
                rem = w - xp;
                last = (rem <= 1) || ($urandom_range(0, 2) == 0);
                if (last) begin
                    s = $urandom_range(0, rem < 127 ? rem : 127);
                    c = $urandom_range(0, (rem - s) < 6 ? rem - s : 6);
                    spr_bytes.push_back(8'(s | 128));
                end else begin
                    s = $urandom_range(0, (rem - 1) < 127 ? rem - 1 : 127);
                    c = $urandom_range(0, (rem - 1 - s) < 6 ? rem - 1 - s : 6);
                    spr_bytes.push_back(8'(s));
                end
                spr_bytes.push_back(8'(c));
                repeat (c) spr_bytes.push_back(8'($urandom));
                xp += s + c;
                if (last) break;
            end
        end
        // a trailing header needs a byte after its count
        repeat ($urandom_range(1, 3)) spr_bytes.push_back(8'($urandom));
        if (corrupt) spr_bytes[$urandom_range(0, spr_bytes.size() - 1)] = 8'($urandom);
        len = spr_bytes.size();
        set_shape(17'(w), 17'(h), 17'(len));
        for (int r = 0; r < h; r++) begin
            send_row(r, row_used[r] ? 32'(row_off[r] + 4 * h) : 32'd0);
            if ($urandom_range(0, 9) == 0) send_query($urandom_range(0, w), $urandom_range(0, h));
        end
        for (int a = 0; a < len; a++) begin
            send_byte(a, spr_bytes[a]);
            if ($urandom_range(0, 9) == 0) send_query($urandom_range(0, w), $urandom_range(0, h));
        end
        // noise: stray bytes past the sprite and random lookups
        repeat ($urandom_range(0, 3))
            send_byte($urandom_range(len, DATA_BYTES_DEF - 1), 8'($urandom));
        drain();
        push_op(rand_op(FN_VERIFY));
        send_query(0, $urandom_range(0, h - 1));
        repeat ($urandom_range(10, 25)) begin
            if ($urandom_range(0, 7) == 0) send_query($urandom, $urandom);
            else send_query($urandom_range(0, w + 2), $urandom_range(0, h));
        end
    endtask

    initial begin
        calm = 0;
        stall_left = 0;
        sent = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // size limits and out-of-range lookups
        push_op(rand_op(FN_VERIFY));
        send_query(0, 0);
        set_shape(17'h1ffff, 17'h1ffff, 17'h1ffff);
        push_op(rand_op(FN_VERIFY));
        send_query(16'hffff, 16'hffff);
        send_query(5, 600);
        set_shape(17'(MAX_WIDTH), 17'(MAX_HEIGHT), 17'd101000);
        push_op(rand_op(FN_VERIFY));
        set_shape(17'd0, 17'd1, 17'd1);
        push_op(rand_op(FN_VERIFY));

        build_sprite(1, 1, 0, 0);
        build_sprite(MAX_WIDTH, MAX_HEIGHT, 1, 0);
        while (sent < 1800) begin
            if ($urandom_range(0, 3) == 0) calm = ~calm;
            build_sprite($urandom_range(0, 5) == 0 ? MAX_WIDTH : $urandom_range(1, 40),
                         $urandom_range(1, 12), 0, $urandom_range(0, 3) == 0);
        end

        // bad row offsets set a sticky error, so they come last
        calm = 0;
        repeat (40) begin
            send_row($urandom, $urandom_range(0, 4) == 0 ? 32'd0 : $urandom);
            if ($urandom_range(0, 3) == 0) send_query($urandom_range(0, 40), $urandom_range(0, 12));
        end
        push_op(rand_op(FN_VERIFY));
        drain();
        repeat (30) @(negedge i_clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("tb_rle_sprite_store_pixel_fetch_core passed");
        end else begin
            $display("tb_rle_sprite_store_pixel_fetch_core failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_rle_sprite_store_pixel_fetch_core failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rle_spr_pkg.sv
rtl/rle_spr_if.sv
rtl/rle_spr_seq.sv
rtl/rle_sprite_store_pixel_fetch_core.sv
dv/tb_rle_sprite_store_pixel_fetch_core.sv
